FILE: hw/rtl/css_stylesheet_lexer_top_macros.svh
// Assertion helpers for the lexer RTL.
`ifndef CSS_STYLESHEET_LEXER_TOP_MACROS_SVH
`define CSS_STYLESHEET_LEXER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSS_LEX_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSS_LEX_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/css_lex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package css_lex_pkg;

	localparam int BUFFER_BYTES  = 256;
	localparam int MAX_SELECTORS = 32;

	// Fill never exceeds BUFFER_BYTES - 1, so this width always holds it.
	localparam int FILL_W  = $clog2(BUFFER_BYTES);
	localparam int COUNT_W = 6;

	localparam logic [FILL_W-1:0]  FILL_LIMIT = FILL_W'(BUFFER_BYTES - 1);
	localparam logic [COUNT_W-1:0] SEL_MAX    = COUNT_W'(MAX_SELECTORS);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [3:0] {
		RG_OUTSIDE  = 4'd0,
		RG_COMMENT  = 4'd1,
		RG_SELECTOR = 4'd3,
		RG_STRING   = 4'd5,
		RG_PROPERTY = 4'd6,
		RG_VALUE    = 4'd7,
		RG_GAP      = 4'd8,
		RG_INNER    = 4'd9
	} region_t;

	typedef enum logic [2:0] {
		EV_BYTE     = 3'd0,
		EV_SELECTOR = 3'd1,
		EV_OPEN     = 3'd2,
		EV_DECL     = 3'd3,
		EV_CLOSE    = 3'd4,
		EV_BRACE    = 3'd5,
		EV_OVERFLOW = 3'd6
	} event_t;

	typedef enum logic [1:0] {
		BUF_SELECTOR = 2'd0,
		BUF_PROPERTY = 2'd1,
		BUF_VALUE    = 2'd2
	} buffer_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_COMMENT_END,
		ACT_COMMENT_OPEN,
		ACT_NUL,
		ACT_SEL_END,
		ACT_OPEN,
		ACT_COLON,
		ACT_DECL,
		ACT_CLOSE,
		ACT_BRACE_ERR,
		ACT_QUOTE,
		ACT_KEEP,
		ACT_OVERFLOW
	} action_t;

	typedef struct packed {
		region_t             region;
		region_t             saved_region;
		buffer_t             current_buffer;
		logic [FILL_W-1:0]   buffer_fill;
		logic [COUNT_W-1:0]  pending_selectors;
		logic [COUNT_W-1:0]  open_rules;
		logic                drop_to_chunk_end;
		logic                aborted;
	} lex_state_t;

	typedef struct packed {
		logic               valid;
		event_t             kind;
		logic [7:0]         kept_byte;
		buffer_t            target_buffer;
		logic [COUNT_W-1:0] open_rule_count;
	} lex_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/css_lex_text_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface css_lex_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       chunk_end;

	modport source (output valid, output text_byte, output chunk_end, input ready);
	modport sink (input valid, input text_byte, input chunk_end, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/css_lex_event_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface css_lex_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] kept_byte;
	logic [1:0] target_buffer;
	logic [5:0] open_rule_count;

	modport source (output valid, output event_kind, output kept_byte,
		output target_buffer, output open_rule_count, input ready);
	modport sink (input valid, input event_kind, input kept_byte,
		input target_buffer, input open_rule_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/css_stylesheet_lexer_top.sv
// Stylesheet lexer.
// The text channel takes one byte per transaction, with chunk_end marking the
// last byte of a chunk. The events channel gives zero or one transaction per
// byte: a kept byte with its buffer, selector end, block open, declaration,
// block close, or one of the two errors (stray brace, buffer overflow).
// Each accepted byte lands in an input register; the region logic evaluates it
// combinationally against the lexer state, and the result register loads the
// outcome when the input register advances, which a stall can hold back.
// Throughput is one byte per cycle while the receiver keeps ready high: the
// input register advances whenever the result register is empty or being
// emptied in the same cycle, and the next state is worked out combinationally.
// When the receiver stalls, the pending result holds and the input register
// keeps the next byte, taking one first if it was empty; text.ready stays low
// until the stall clears.
// Reset (arst_n low) empties both registers and returns the lexer to the
// outside-rules region with all counters cleared. After an error event every
// further byte is consumed without producing a transaction until reset.
`timescale 1ns / 1ps
`default_nettype none
`include "css_stylesheet_lexer_top_macros.svh"

module css_stylesheet_lexer_top (
	input logic            clk,
	input logic            arst_n,
	css_lex_text_if.sink   text,
	css_lex_event_if.source events
);
	import css_lex_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	lex_state_t  state_q;
	lex_state_t  state_next;
	lex_result_t res;
	logic        out_valid_q;
	event_t      out_kind_q;
	logic [7:0]  out_byte_q;
	buffer_t     out_buf_q;
	logic [COUNT_W-1:0] out_count_q;
	logic        advance;

	assign advance    = valid_s1 && (!out_valid_q || events.ready);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.chunk_end;
		end
	end

	css_lex_step u_step (
		.st        (state_q),
		.text_byte (byte_s1),
		.chunk_end (last_s1),
		.st_next   (state_next),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{region: RG_OUTSIDE, saved_region: RG_OUTSIDE,
				current_buffer: BUF_SELECTOR, buffer_fill: '0, pending_selectors: '0,
				open_rules: '0, drop_to_chunk_end: 1'b0, aborted: 1'b0};
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_kind_q  <= res.kind;
			out_byte_q  <= res.kept_byte;
			out_buf_q   <= res.target_buffer;
			out_count_q <= res.open_rule_count;
		end
	end

	assign events.valid           = out_valid_q;
	assign events.event_kind      = out_kind_q;
	assign events.kept_byte       = out_byte_q;
	assign events.target_buffer   = out_buf_q;
	assign events.open_rule_count = out_count_q;

	`CSS_LEX_ASSERT_NEXT(a_abort_sticky, clk, arst_n, state_q.aborted, state_q.aborted,
		"abort flag cleared without reset")
	`CSS_LEX_ASSERT_NOW(a_quiet_after_abort, clk, arst_n, state_q.aborted && advance,
		!res.valid, "result produced after abort")
	`CSS_LEX_ASSERT_NOW(a_rules_bounded, clk, arst_n, 1'b1,
		state_q.open_rules <= SEL_MAX && state_q.pending_selectors <= SEL_MAX,
		"selector count above limit")
	`CSS_LEX_ASSERT_NEXT(a_stall_holds_item, clk, arst_n,
		valid_s1 && out_valid_q && !events.ready, valid_s1 && $stable(state_q),
		"input item or state moved during stall")

endmodule

`default_nettype wire

FILE: hw/rtl/css_lex_step.sv
`timescale 1ns / 1ps
`default_nettype none

module css_lex_step (
	input  css_lex_pkg::lex_state_t  st,
	input  logic [7:0]               text_byte,
	input  logic                     chunk_end,
	output css_lex_pkg::lex_state_t  st_next,
	output css_lex_pkg::lex_result_t res
);
	import css_lex_pkg::*;

	logic       blank;
	logic       sel_start;
	logic       skip_blank;
	region_t    keep_region;
	buffer_t    keep_buffer;
	logic [FILL_W-1:0] keep_fill;
	action_t    act;
	logic [COUNT_W-1:0] pend_open;
	logic [COUNT_W:0]   rule_sum;
	logic [COUNT_W-1:0] rules_sat;

	assign blank = (text_byte == CH_SPACE) ||
		(text_byte >= CH_TAB && text_byte <= CH_CR);
	assign sel_start = (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
		(text_byte >= 8'h61 && text_byte <= 8'h7A) ||
		(text_byte == CH_STAR) || (text_byte == CH_DOT) || (text_byte == CH_HASH);
	assign skip_blank = blank && (st.region == RG_OUTSIDE || st.region == RG_PROPERTY ||
		st.region == RG_INNER || st.region == RG_GAP);

	// Region, buffer and fill a non-structural byte sees once the gaps resolve.
	always_comb begin
		keep_region = st.region;
		keep_buffer = st.current_buffer;
		keep_fill   = st.buffer_fill;
		if (!blank && st.region == RG_INNER) begin
			keep_region = RG_PROPERTY;
			keep_buffer = BUF_PROPERTY;
			keep_fill   = '0;
		end else if (!blank && st.region == RG_GAP) begin
			keep_region = RG_VALUE;
			keep_buffer = BUF_VALUE;
			keep_fill   = '0;
		end
		if (text_byte != CH_QUOTE && sel_start && keep_region == RG_OUTSIDE) begin
			keep_region = RG_SELECTOR;
			keep_buffer = BUF_SELECTOR;
			keep_fill   = '0;
		end
	end

	// A selector still open at '{' counts as pending before the rules are added.
	assign pend_open = (st.region == RG_SELECTOR && st.pending_selectors < SEL_MAX) ?
		st.pending_selectors + COUNT_W'(1) : st.pending_selectors;
	assign rule_sum  = {1'b0, st.open_rules} + {1'b0, pend_open};
	assign rules_sat = (rule_sum > {1'b0, SEL_MAX}) ? SEL_MAX : rule_sum[COUNT_W-1:0];

	always_comb begin
		if (st.aborted || st.drop_to_chunk_end || skip_blank) begin
			act = ACT_NONE;
		end else if (st.region == RG_COMMENT) begin
			act = (text_byte == CH_SLASH) ? ACT_COMMENT_END : ACT_NONE;
		end else if (text_byte == CH_SLASH) begin
			act = ACT_COMMENT_OPEN;
		end else if (text_byte == CH_NUL) begin
			act = ACT_NUL;
		end else if (text_byte == CH_COMMA && st.region == RG_SELECTOR) begin
			act = ACT_SEL_END;
		end else if (text_byte == CH_LBRACE) begin
			act = ACT_OPEN;
		end else if (text_byte == CH_COLON && st.region == RG_PROPERTY) begin
			act = ACT_COLON;
		end else if (text_byte == CH_SEMI && st.region == RG_VALUE) begin
			act = ACT_DECL;
		end else if (text_byte == CH_RBRACE) begin
			act = (st.region == RG_VALUE || st.region == RG_INNER) ? ACT_CLOSE :
				ACT_BRACE_ERR;
		end else if (text_byte == CH_QUOTE) begin
			act = ACT_QUOTE;
		end else if (keep_fill >= FILL_LIMIT) begin
			act = ACT_OVERFLOW;
		end else begin
			act = ACT_KEEP;
		end
	end

	always_comb begin
		st_next = st;
		unique case (act)
			ACT_NONE: begin
				if (st.drop_to_chunk_end && !st.aborted && chunk_end) begin
					st_next.drop_to_chunk_end = 1'b0;
				end
			end
			ACT_COMMENT_END: begin
				st_next.region       = st.saved_region;
				st_next.saved_region = RG_OUTSIDE;
			end
			ACT_COMMENT_OPEN: begin
				st_next.saved_region = st.region;
				st_next.region       = RG_COMMENT;
			end
			ACT_NUL: begin
				st_next.drop_to_chunk_end = !chunk_end;
			end
			ACT_SEL_END: begin
				if (st.pending_selectors < SEL_MAX) begin
					st_next.pending_selectors = st.pending_selectors + COUNT_W'(1);
				end
				st_next.current_buffer = BUF_SELECTOR;
				st_next.buffer_fill    = '0;
				st_next.region         = RG_OUTSIDE;
			end
			ACT_OPEN: begin
				if (st.region == RG_SELECTOR) begin
					st_next.current_buffer = BUF_SELECTOR;
					st_next.buffer_fill    = '0;
				end
				st_next.open_rules        = rules_sat;
				st_next.pending_selectors = '0;
				st_next.region            = RG_INNER;
			end
			ACT_COLON: begin
				st_next.region = RG_GAP;
			end
			ACT_DECL: begin
				st_next.region = RG_INNER;
			end
			ACT_CLOSE: begin
				st_next.open_rules = '0;
				st_next.region     = RG_OUTSIDE;
			end
			ACT_BRACE_ERR, ACT_OVERFLOW: begin
				st_next.aborted = 1'b1;
			end
			ACT_QUOTE: begin
				st_next.current_buffer = keep_buffer;
				st_next.buffer_fill    = keep_fill;
				if (keep_region == RG_STRING) begin
					st_next.region       = st.saved_region;
					st_next.saved_region = RG_OUTSIDE;
				end else begin
					st_next.saved_region = keep_region;
					st_next.region       = RG_STRING;
				end
			end
			ACT_KEEP: begin
				st_next.region         = keep_region;
				st_next.current_buffer = keep_buffer;
				st_next.buffer_fill    = keep_fill + FILL_W'(1);
			end
			default: begin
				st_next = st;
			end
		endcase
	end

	always_comb begin
		res = '{valid: 1'b0, kind: EV_BYTE, kept_byte: 8'h00,
			target_buffer: BUF_SELECTOR, open_rule_count: '0};
		unique case (act)
			ACT_SEL_END: begin
				res.valid = 1'b1;
				res.kind  = EV_SELECTOR;
			end
			ACT_OPEN: begin
				res.valid           = 1'b1;
				res.kind            = EV_OPEN;
				res.open_rule_count = rules_sat;
			end
			ACT_DECL: begin
				res.valid           = 1'b1;
				res.kind            = EV_DECL;
				res.open_rule_count = st.open_rules;
			end
			ACT_CLOSE: begin
				res.valid = 1'b1;
				res.kind  = EV_CLOSE;
				// Closing straight out of a value also completes that declaration.
				if (st.region == RG_VALUE) begin
					res.target_buffer   = BUF_VALUE;
					res.open_rule_count = st.open_rules;
				end
			end
			ACT_BRACE_ERR: begin
				res.valid = 1'b1;
				res.kind  = EV_BRACE;
			end
			ACT_OVERFLOW: begin
				res.valid = 1'b1;
				res.kind  = EV_OVERFLOW;
			end
			ACT_KEEP: begin
				res.valid         = 1'b1;
				res.kind          = EV_BYTE;
				res.kept_byte     = text_byte;
				res.target_buffer = keep_buffer;
			end
			default: begin
				res.valid = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import css_lex_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 60;

	localparam string SEL_START  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ*.#";
	localparam string SEL_BODY   = "abcdefgxyzQRS0123456789-_.#:>[]=~+ ";
	localparam string PROP_BODY  = "abcdefghijklmnopqrstuvwxyz-";
	localparam string VALUE_BODY = "0123456789abcdefpx%#.-(),! ";
	localparam string BLANKS     = " \t\n\v\f\r";

	typedef struct packed {
		event_t             kind;
		logic [7:0]         kept;
		buffer_t            target;
		logic [COUNT_W-1:0] rules;
	} lex_event_t;

	logic clk;
	logic arst_n;

	css_lex_text_if  text_ch ();
	css_lex_event_if event_ch ();

	css_stylesheet_lexer_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.events (event_ch)
	);

	// Lexer state as the predictor sees it.
	region_t lx_region;
	region_t lx_saved;
	buffer_t lx_buffer;
	int      lx_fill;
	int      lx_pending;
	int      lx_open;
	bit      lx_dropping;
	bit      lx_halted;

	lex_event_t lexer_events_q[$];
	int         items_sent;
	int         fail_count;
	int         cycle_count;
	int         tx_gap_max;
	int         rx_stall_max;
	int         hold_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[css_stylesheet_lexer_top] ERROR");
			$finish;
		end
	end

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void switch_buffer(input buffer_t b);
		lx_buffer = b;
		lx_fill   = 0;
	endfunction

	// Advances the lexer state by one byte; returns 1 when the byte produces an event.
	function automatic bit lex_next_event(input logic [7:0] c, input logic last,
			output lex_event_t ev);
		ev = '{EV_BYTE, 8'h00, BUF_SELECTOR, '0};
		if (lx_halted)
			return 0;
		if (lx_dropping) begin
			if (last)
				lx_dropping = 0;
			return 0;
		end
		if (is_blank(c) && (lx_region inside {RG_OUTSIDE, RG_PROPERTY, RG_INNER, RG_GAP}))
			return 0;
		if (lx_region == RG_COMMENT) begin
			if (c == CH_SLASH) begin
				lx_region = lx_saved;
				lx_saved  = RG_OUTSIDE;
			end
			return 0;
		end
		if (c == CH_SLASH) begin
			lx_saved  = lx_region;
			lx_region = RG_COMMENT;
			return 0;
		end
		if (c == CH_NUL) begin
			lx_dropping = !last;
			return 0;
		end
		if (c == CH_COMMA && lx_region == RG_SELECTOR) begin
			if (lx_pending < MAX_SELECTORS)
				lx_pending++;
			switch_buffer(BUF_SELECTOR);
			lx_region = RG_OUTSIDE;
			ev.kind = EV_SELECTOR;
			return 1;
		end
		if (c == CH_LBRACE) begin
			if (lx_region == RG_SELECTOR) begin
				if (lx_pending < MAX_SELECTORS)
					lx_pending++;
				switch_buffer(BUF_SELECTOR);
			end
			lx_open += lx_pending;
			if (lx_open > MAX_SELECTORS)
				lx_open = MAX_SELECTORS;
			lx_pending = 0;
			lx_region  = RG_INNER;
			ev.kind  = EV_OPEN;
			ev.rules = COUNT_W'(lx_open);
			return 1;
		end
		if (c == CH_COLON && lx_region == RG_PROPERTY) begin
			lx_region = RG_GAP;
			return 0;
		end
		if (c == CH_SEMI && lx_region == RG_VALUE) begin
			lx_region = RG_INNER;
			ev.kind  = EV_DECL;
			ev.rules = COUNT_W'(lx_open);
			return 1;
		end
		if (c == CH_RBRACE) begin
			if (lx_region == RG_VALUE) begin
				// The pending declaration completes together with the close.
				ev.target = BUF_VALUE;
				ev.rules  = COUNT_W'(lx_open);
			end else if (lx_region != RG_INNER) begin
				lx_halted = 1;
				ev.kind = EV_BRACE;
				return 1;
			end
			lx_open   = 0;
			lx_region = RG_OUTSIDE;
			ev.kind = EV_CLOSE;
			return 1;
		end
		if (!is_blank(c)) begin
			if (lx_region == RG_INNER) begin
				lx_region = RG_PROPERTY;
				switch_buffer(BUF_PROPERTY);
			end
			if (lx_region == RG_GAP) begin
				lx_region = RG_VALUE;
				switch_buffer(BUF_VALUE);
			end
		end
		if (c == CH_QUOTE) begin
			if (lx_region == RG_STRING) begin
				lx_region = lx_saved;
				lx_saved  = RG_OUTSIDE;
			end else begin
				lx_saved  = lx_region;
				lx_region = RG_STRING;
			end
			return 0;
		end
		if ((is_letter(c) || c == CH_STAR || c == CH_DOT || c == CH_HASH) &&
				lx_region == RG_OUTSIDE) begin
			lx_region = RG_SELECTOR;
			switch_buffer(BUF_SELECTOR);
		end
		if (lx_fill + 2 > BUFFER_BYTES) begin
			lx_halted = 1;
			ev.kind = EV_OVERFLOW;
			return 1;
		end
		lx_fill++;
		ev.kind   = EV_BYTE;
		ev.kept   = c;
		ev.target = lx_buffer;
		return 1;
	endfunction

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic chunk_flag();
		return $urandom_range(0, 9) == 0;
	endfunction

	// A brace is harmless only where it closes a block or is ignored.
	function automatic bit brace_is_safe();
		return lx_halted || lx_dropping || (lx_region inside {RG_COMMENT, RG_INNER, RG_VALUE});
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		lex_event_t ev;
		gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
		repeat (gap) begin
			@(negedge clk);
			text_ch.valid = 1'b0;
		end
		@(negedge clk);
		text_ch.valid     = 1'b1;
		text_ch.text_byte = b;
		text_ch.chunk_end = last;
		do
			@(posedge clk);
		while (!text_ch.ready);
		if (lex_next_event(b, last, ev))
			lexer_events_q.push_back(ev);
		items_sent++;
	endtask

	task automatic send_text(input string s, input logic last);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], (i == s.len() - 1) ? last : 1'b0);
	endtask

	task automatic send_item(input logic [7:0] b);
		if (b == CH_RBRACE && !brace_is_safe())
			b = CH_SEMI;
		send_byte(b, chunk_flag());
	endtask

	task automatic maybe_blank();
		if ($urandom_range(0, 2) == 0)
			send_item(pick(BLANKS));
	endtask

	task automatic send_comment();
		logic [7:0] b;
		send_item(CH_SLASH);
		repeat ($urandom_range(0, 5)) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == CH_SLASH);
			send_item(b);
		end
		send_item(CH_SLASH);
	endtask

	task automatic send_rule();
		int nsel;
		int ndecl;
		int i;
		int j;
		nsel  = $urandom_range(1, 3);
		ndecl = $urandom_range(0, 3);
		for (i = 0; i < nsel; i++) begin
			if (i > 0) begin
				send_item(CH_COMMA);
				maybe_blank();
			end
			send_item(pick(SEL_START));
			repeat ($urandom_range(0, 5))
				send_item(pick(SEL_BODY));
		end
		maybe_blank();
		send_item(CH_LBRACE);
		for (j = 0; j < ndecl; j++) begin
			maybe_blank();
			if ($urandom_range(0, 5) == 0)
				send_comment();
			repeat ($urandom_range(1, 6))
				send_item(pick(PROP_BODY));
			maybe_blank();
			send_item(CH_COLON);
			maybe_blank();
			repeat ($urandom_range(1, 6))
				send_item(pick(VALUE_BODY));
			if ($urandom_range(0, 4) == 0) begin
				send_item(CH_QUOTE);
				repeat ($urandom_range(0, 4))
					send_item(pick(VALUE_BODY));
				send_item(CH_QUOTE);
			end
			if (j < ndecl - 1 || $urandom_range(0, 1) == 0)
				send_item(CH_SEMI);
		end
		maybe_blank();
		send_item(CH_RBRACE);
	endtask

	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 6)) begin
			b = ($urandom_range(0, 7) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
			send_item(b);
		end
	endtask

	// Walks the lexer back to the outside region with no chunk being dropped, unless it has halted.
	task automatic settle();
		while (!lx_halted && (lx_dropping || lx_region != RG_OUTSIDE)) begin
			if (lx_dropping)
				send_byte(CH_SPACE, 1'b1);
			else begin
				case (lx_region)
					RG_COMMENT: send_byte(CH_SLASH, 1'b0);
					RG_STRING: send_byte(CH_QUOTE, 1'b0);
					RG_INNER, RG_VALUE: send_byte(CH_RBRACE, 1'b0);
					RG_PROPERTY: send_byte(CH_COLON, 1'b0);
					RG_GAP: send_byte("x", 1'b0);
					default: send_byte(CH_COMMA, 1'b0);
				endcase
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		text_ch.valid = 1'b0;
		while (lexer_events_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic pick_idle_mode();
		tx_gap_max   = $urandom_range(0, 1) ? 9 : 0;
		rx_stall_max = $urandom_range(0, 1) ? 9 : 0;
	endtask

	task automatic test_selectors_and_blocks();
		send_text("a,b{ c : v;p:\"q;\"}\nd{}*.x#y{}", 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_text("9,:;", 1'b0);
		wait_drained();
	endtask

	task automatic test_comments_and_strings();
		// The comment inside the string clears the saved region, so the
		// closing quote lands outside the block.
		send_text("/}{/e /c/f{x:1/z/2}g{h:\"i/j/k\"l,m{}h{{}", 1'b0);
		wait_drained();
	endtask

	task automatic test_chunk_drop();
		send_byte("a", 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte("b", 1'b0);
		send_byte(CH_RBRACE, 1'b1);
		send_byte("c", 1'b0);
		send_byte(CH_NUL, 1'b1);
		send_text("d{}", 1'b1);
		wait_drained();
	endtask

	task automatic test_selector_saturation();
		repeat (MAX_SELECTORS + 2)
			send_text("s,", 1'b0);
		send_text("t{u:v;}", 1'b0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		tx_gap_max   = 0;
		rx_stall_max = 0;
		hold_cycles  = HOLD_CYCLES;
		send_text("a{p:vvvvvvvvvvvvvvvvvvvv;q:w}", 1'b0);
		wait_drained();
		tx_gap_max   = 9;
		rx_stall_max = 9;
	endtask

	task automatic test_random_stream();
		int stop_at;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0)
				pick_idle_mode();
			if ($urandom_range(0, 4) != 0)
				send_rule();
			else begin
				send_noise();
				settle();
			end
		end
		tx_gap_max   = 9;
		rx_stall_max = 9;
		wait_drained();
	endtask

	// Either error stops the lexer for good, so the run ends with one of them.
	task automatic test_error_stop();
		settle();
		if ($urandom_range(0, 1))
			send_text("q}", 1'b0);
		else begin
			tx_gap_max = 0;
			while (!lx_halted)
				send_byte(pick(PROP_BODY), 1'b0);
			tx_gap_max = 9;
		end
		repeat (12)
			send_byte(8'($urandom_range(0, 255)), chunk_flag());
		wait_drained();
	endtask

	initial begin : event_sink
		int stall;
		event_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				event_ch.ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else if (rx_stall_max > 0) begin
				stall = $urandom_range(0, rx_stall_max);
				if (stall > 0) begin
					event_ch.ready = 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			event_ch.ready = 1'b1;
			do
				@(posedge clk);
			while (!event_ch.valid);
			if (lexer_events_q.size() == 0) begin
				$display("%0t: unexpected event: expected none, actual %0d/%h/%0d/%0d",
					$time, event_ch.event_kind, event_ch.kept_byte,
					event_ch.target_buffer, event_ch.open_rule_count);
				fail_count++;
			end else begin : compare
				lex_event_t ev;
				ev = lexer_events_q.pop_front();
				if (event_ch.event_kind !== ev.kind || event_ch.kept_byte !== ev.kept ||
						event_ch.target_buffer !== ev.target ||
						event_ch.open_rule_count !== ev.rules) begin
					$display("%0t: event mismatch: expected %0d/%h/%0d/%0d, actual %0d/%h/%0d/%0d",
						$time, ev.kind, ev.kept, ev.target, ev.rules,
						event_ch.event_kind, event_ch.kept_byte,
						event_ch.target_buffer, event_ch.open_rule_count);
					fail_count++;
				end
			end
		end
	end

	initial begin
		text_ch.valid     = 1'b0;
		text_ch.text_byte = 8'h00;
		text_ch.chunk_end = 1'b0;
		tx_gap_max   = 9;
		rx_stall_max = 9;
		hold_cycles  = 0;
		items_sent   = 0;
		fail_count   = 0;
		cycle_count  = 0;
		lx_region    = RG_OUTSIDE;
		lx_saved     = RG_OUTSIDE;
		lx_buffer    = BUF_SELECTOR;
		lx_fill      = 0;
		lx_pending   = 0;
		lx_open      = 0;
		lx_dropping  = 0;
		lx_halted    = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_selectors_and_blocks();
		test_comments_and_strings();
		test_chunk_drop();
		test_selector_saturation();
		test_backpressure();
		test_random_stream();
		test_error_stop();

		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("[css_stylesheet_lexer_top] OK");
		else
			$display("[css_stylesheet_lexer_top] ERROR");
		$finish;
	end

endmodule
